>>> hw/rtl/rcs_pkg.sv
// Shared types and constants of the radio contact sequencer.
`default_nettype none
package rcs_pkg;

    localparam int unsigned RCS_MAX_MESSAGES = 64;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_FULL = '1;
    localparam int unsigned IN_TDATA_W = 24;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_DATA_W = 4;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_CQ         = 4'd1,
        ST_REPORT     = 4'd2,
        ST_RR73       = 4'd3,
        ST_ANSWER     = 4'd4,
        ST_ANS_REPORT = 4'd5,
        ST_SEND_73    = 4'd6,
        ST_DONE_73    = 4'd7,
        ST_REPORT_RPT = 4'd8,
        ST_RR73_RPT   = 4'd9,
        ST_ANSWER_RPT = 4'd10
    } state_t;

    typedef enum logic [2:0] {
        MSG_CQ         = 3'd0,
        MSG_ANSWER_CQ  = 3'd1,
        MSG_REPORT     = 3'd2,
        MSG_RR73       = 3'd3,
        MSG_ANS_REPORT = 3'd4,
        MSG_FINAL_73   = 3'd5
    } msg_kind_t;

    typedef enum logic {
        CFG_AUTO_CQ      = 1'b0,
        CFG_MAX_ATTEMPTS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             auto_cq;
        logic [CNT_W-1:0] max_attempts;
    } cfg_t;

    typedef struct packed {
        logic             final_73;
        logic             rr73_after_report;
        logic             report_for_our_answer;
        logic             report_for_our_cq;
        logic [IDX_W-1:0] partner_index;
        logic             partner_found;
        logic [IDX_W-1:0] caller_index;
        logic             caller_found;
    } item_t;

    typedef struct packed {
        logic             cq_button_off;
        logic             record_start;
        logic             clear_target;
        logic             log_contact;
        logic [IDX_W-1:0] target_index;
        logic             load_target;
        logic [3:0]       next_state;
        msg_kind_t        message_kind;
        logic             transmit;
    } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/radio_contact_sequencer_core.sv
// Top level of the radio contact sequencer: stream ports, registers and config.
`default_nettype none
// The sequencer takes one transfer per receive period on s_axis and returns
// exactly one result transfer on m_axis for it, in order. It accepts a new
// item every clock cycle unless m_axis_tready stalls the result register;
// items pass the input register, then the result register. Combinational
// next-state logic feeding the contact state and retry counter registers
// sets the rate. The user must write auto_cq and max_attempts via cfg_wr_en /
// cfg_addr / cfg_wdata with no item in flight; the block does not enforce it.
module radio_contact_sequencer_core #(
    parameter int unsigned MAX_MESSAGES = rcs_pkg::RCS_MAX_MESSAGES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // caller_found, caller_index[6], partner_found, partner_index[6],
    // report_for_our_cq, report_for_our_answer, rr73_after_report, final_73
    input  logic [rcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // transmit, message_kind[3], next_state[4], load_target, target_index[6],
    // log_contact, clear_target, record_start, cq_button_off
    output logic [rcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import rcs_pkg::*;

    localparam int unsigned ITEM_W = $bits(item_t);
    localparam int unsigned RES_W  = $bits(result_t);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    state_t           state_reg;
    logic [CNT_W-1:0] retry_reg;

    state_t           state_next;
    logic [CNT_W-1:0] retry_next;
    result_t          res_next;
    logic             advance;
    logic             s_xfer;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    rcs_step #(
        .MAX_MESSAGES(MAX_MESSAGES)
    ) u_step (
        .cfg_i    (cfg_reg),
        .item_i   (in_item_reg),
        .state_i  (state_reg),
        .retry_i  (retry_reg),
        .state_o  (state_next),
        .retry_o  (retry_next),
        .result_o (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_cq      <= 1'b0;
            cfg_reg.max_attempts <= CNT_W'(3);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_AUTO_CQ:      cfg_reg.auto_cq      <= cfg_wdata[0];
                CFG_MAX_ATTEMPTS: cfg_reg.max_attempts <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            retry_reg     <= '0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                retry_reg     <= retry_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_reg};

endmodule
`default_nettype wire

>>> hw/rtl/rcs_step.sv
// Next-state, retry counter and result logic for one receive period.
`default_nettype none
module rcs_step #(
    parameter int unsigned MAX_MESSAGES = rcs_pkg::RCS_MAX_MESSAGES
) (
    input  rcs_pkg::cfg_t                 cfg_i,
    input  rcs_pkg::item_t                item_i,
    input  rcs_pkg::state_t               state_i,
    input  logic [rcs_pkg::CNT_W-1:0]     retry_i,
    output rcs_pkg::state_t               state_o,
    output logic [rcs_pkg::CNT_W-1:0]     retry_o,
    output rcs_pkg::result_t              result_o
);
    import rcs_pkg::*;

    localparam logic [8:0] IDX_LIMIT = 9'(MAX_MESSAGES - 1);

    state_t           st;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] src_idx;
    logic [8:0]       src_wide;
    logic [IDX_W-1:0] clamped;
    result_t          res;

    always_comb begin
        st      = state_i;
        retry_o = retry_i;
        cnt     = retry_i;
        src_idx = item_i.partner_index;
        res     = '0;

        if (!item_i.caller_found) begin
            if (st != ST_IDLE && st != ST_CQ) begin
                if (st == ST_ANSWER) begin
                    cnt = '0;
                end
                if (cnt != CNT_FULL) begin
                    cnt = cnt + 1'b1;
                end
                if (cnt < cfg_i.max_attempts) begin
                    retry_o = cnt;
                    if (st == ST_REPORT) begin
                        st = ST_REPORT_RPT;
                    end else if (st == ST_RR73) begin
                        st = ST_RR73_RPT;
                    end else if (st == ST_ANSWER) begin
                        st = ST_ANSWER_RPT;
                    end
                end else begin
                    res.clear_target = 1'b1;
                    retry_o          = '0;
                    if (cfg_i.auto_cq) begin
                        st = ST_CQ;
                    end else begin
                        st                = ST_IDLE;
                        res.cq_button_off = 1'b1;
                    end
                end
            end else begin
                st = ST_CQ;
            end
        end else begin
            unique case (st)
                ST_CQ: begin
                    res.record_start = 1'b1;
                    st               = ST_REPORT;
                    retry_o          = '0;
                    src_idx          = item_i.caller_index;
                end
                ST_REPORT, ST_REPORT_RPT: begin
                    if (item_i.partner_found) begin
                        retry_o = '0;
                        if (item_i.report_for_our_cq) begin
                            st = ST_RR73;
                        end else if (item_i.rr73_after_report) begin
                            st               = ST_SEND_73;
                            res.log_contact  = 1'b1;
                            res.clear_target = 1'b1;
                        end
                    end else begin
                        st = ST_REPORT_RPT;
                    end
                end
                ST_RR73, ST_RR73_RPT: begin
                    if (item_i.partner_found) begin
                        retry_o = '0;
                        if (item_i.final_73) begin
                            res.log_contact  = 1'b1;
                            res.clear_target = 1'b1;
                            if (cfg_i.auto_cq) begin
                                st = ST_CQ;
                            end else begin
                                st                = ST_IDLE;
                                res.cq_button_off = 1'b1;
                            end
                        end
                    end else begin
                        st = ST_RR73_RPT;
                    end
                end
                ST_ANSWER, ST_ANSWER_RPT: begin
                    if (item_i.partner_found) begin
                        retry_o = '0;
                        if (item_i.report_for_our_answer) begin
                            st               = ST_ANS_REPORT;
                            res.record_start = 1'b1;
                        end
                    end else begin
                        st = ST_ANSWER_RPT;
                    end
                end
                ST_ANS_REPORT: begin
                    if (item_i.partner_found) begin
                        retry_o = '0;
                        if (item_i.rr73_after_report) begin
                            st              = ST_SEND_73;
                            res.log_contact = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        src_wide = {3'b000, src_idx};
        clamped  = (src_wide > IDX_LIMIT) ? IDX_LIMIT[IDX_W-1:0] : src_idx;

        unique case (st)
            ST_CQ: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_CQ;
            end
            ST_REPORT: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_REPORT;
                res.load_target  = 1'b1;
                res.target_index = clamped;
            end
            ST_RR73, ST_RR73_RPT: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_RR73;
            end
            ST_REPORT_RPT: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_REPORT;
            end
            ST_ANS_REPORT: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_ANS_REPORT;
            end
            ST_SEND_73: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_FINAL_73;
                st               = ST_DONE_73;
            end
            ST_ANSWER_RPT: begin
                res.transmit     = 1'b1;
                res.message_kind = MSG_ANSWER_CQ;
            end
            default: begin
            end
        endcase

        res.next_state = st;
        state_o        = st;
        result_o       = res;
    end

endmodule
`default_nettype wire
